### design/rabs_pkg.sv
// Shared types, register codes and fixed constants of the background subtraction unit.
package rabs_pkg;

   localparam int LR_WIDTH       = 17;
   localparam int LIMIT_WIDTH    = 8;
   localparam int PPF_WIDTH      = 20;
   localparam int CSR_DATA_WIDTH = 20;

   localparam logic [LR_WIDTH-1:0]    LR_ONE      = 17'd65536;
   localparam logic [LR_WIDTH-1:0]    LR_RESET    = 17'd32768;
   localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = 8'd25;
   localparam int                     PPF_RESET   = 307200;

   localparam int LR_SHIFT   = 16;
   localparam int ROUND_HALF = 32768;

   localparam int GRAY_SUM_WIDTH = 22;
   localparam int GRAY_SHIFT     = 14;
   localparam logic [GRAY_SUM_WIDTH-1:0] WEIGHT_RED   = 22'd4899;
   localparam logic [GRAY_SUM_WIDTH-1:0] WEIGHT_GREEN = 22'd9617;
   localparam logic [GRAY_SUM_WIDTH-1:0] WEIGHT_BLUE  = 22'd1868;
   localparam logic [GRAY_SUM_WIDTH-1:0] GRAY_ROUND   = 22'd8192;

   localparam int FIFO_DEPTH       = 4;
   localparam int FIFO_PTR_WIDTH   = 2;
   localparam int FIFO_COUNT_WIDTH = 3;

   typedef enum logic [1:0] {
      CSR_LEARNING_RATE    = 2'd0,
      CSR_DIFFERENCE_LIMIT = 2'd1,
      CSR_PIXELS_PER_FRAME = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic       is_background;
      logic [7:0] gray_level;
      logic [7:0] background_level;
      logic       frame_end;
   } result_type;

   function automatic logic [7:0] to_gray(input logic [7:0] red,
                                          input logic [7:0] green,
                                          input logic [7:0] blue);
      logic [GRAY_SUM_WIDTH-1:0] sum;
      sum = WEIGHT_RED * GRAY_SUM_WIDTH'(red) + WEIGHT_GREEN * GRAY_SUM_WIDTH'(green)
          + WEIGHT_BLUE * GRAY_SUM_WIDTH'(blue) + GRAY_ROUND;
      return sum[GRAY_SUM_WIDTH-1:GRAY_SHIFT];
   endfunction

endpackage

### design/rabs_store_mem.sv
// Background store: synchronous single-write, single-read memory with registered read data.
module rabs_store_mem #(
   parameter int DEPTH      = 524288,
   parameter int WIDTH      = 24,
   parameter int ADDR_WIDTH = $clog2(DEPTH)
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_WIDTH-1:0] wr_addr,
   input  logic [WIDTH-1:0]      wr_data,
   input  logic                  rd_en,
   input  logic [ADDR_WIDTH-1:0] rd_addr,
   output logic [WIDTH-1:0]      rd_data_ff
);

   logic [WIDTH-1:0] entries_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entries_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= entries_ff[rd_addr];
      end
   end

endmodule

### design/rabs_update_pipe.sv
// Read-modify-write pipeline: classification, background update and write-back forwarding.
module rabs_update_pipe
   import rabs_pkg::*;
#(
   parameter int ADDR_WIDTH    = 19,
   parameter int FRACTION_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [LR_WIDTH-1:0]        learning_rate,
   input  logic [LIMIT_WIDTH-1:0]     difference_limit,
   input  logic                       issue_valid,
   input  logic [ADDR_WIDTH-1:0]      issue_addr,
   input  logic [7:0]                 issue_gray,
   input  logic                       issue_last,
   input  logic                       issue_primed,
   input  logic [ADDR_WIDTH-1:0]      probe_addr,
   output logic                       conflict,
   input  logic [8+FRACTION_BITS-1:0] mem_rd_data,
   output logic                       mem_wr_en,
   output logic [ADDR_WIDTH-1:0]      mem_wr_addr,
   output logic [8+FRACTION_BITS-1:0] mem_wr_data,
   output logic                       push_valid,
   output result_type                 push_data
);

   localparam int SW  = 8 + FRACTION_BITS;
   localparam int DW  = SW + 1;
   localparam int PW  = DW + LR_WIDTH + 1;
   localparam int TW  = PW + 1;
   localparam int STW = TW - LR_SHIFT;
   localparam int NW  = SW + 5;
   localparam logic [SW-1:0] TOP = {8'hFF, {FRACTION_BITS{1'b0}}};

   logic                  s1_valid_ff, s1_valid_in;
   logic [ADDR_WIDTH-1:0] s1_addr_ff;
   logic [7:0]            s1_gray_ff;
   logic                  s1_last_ff;
   logic                  s1_primed_ff;

   logic                  s2_write_ff, s2_write_in;
   logic [ADDR_WIDTH-1:0] s2_addr_ff;
   logic [SW-1:0]         s2_bg_ff;
   logic signed [DW-1:0]  s2_delta_ff;

   logic                  s3_write_ff, s3_write_in;
   logic [ADDR_WIDTH-1:0] s3_addr_ff;
   logic [SW-1:0]         s3_bg_ff;
   logic signed [PW-1:0]  s3_product_ff;

   logic                  wb_valid_ff, wb_valid_in;
   logic [ADDR_WIDTH-1:0] wb_addr_ff;
   logic [SW-1:0]         wb_data_ff;

   logic [SW-1:0]         s1_bg;
   logic [7:0]            s1_whole;
   logic [FRACTION_BITS-1:0] s1_frac;
   logic                  s1_round_up;
   logic [7:0]            s1_level;
   logic [7:0]            s1_diff;
   logic                  s1_is_bg;
   logic signed [DW-1:0]  s1_delta;

   logic signed [PW-1:0]  s2_product;

   logic signed [TW-1:0]  s3_total;
   logic signed [STW-1:0] s3_step;
   logic signed [NW-1:0]  s3_sum;
   logic [SW-1:0]         s3_new_bg;

   always_comb begin
      if (!s1_primed_ff) begin
         s1_bg = {s1_gray_ff, {FRACTION_BITS{1'b0}}};
      end else if (wb_valid_ff && (wb_addr_ff == s1_addr_ff)) begin
         s1_bg = wb_data_ff;
      end else begin
         s1_bg = mem_rd_data;
      end
      s1_whole    = s1_bg[SW-1:FRACTION_BITS];
      s1_frac     = s1_bg[FRACTION_BITS-1:0];
      s1_round_up = s1_frac[FRACTION_BITS-1] && ((|s1_frac[FRACTION_BITS-2:0]) || s1_whole[0]);
      s1_level    = (s1_round_up && (s1_whole != 8'hFF)) ? s1_whole + 8'd1 : s1_whole;
      s1_diff     = (s1_level > s1_gray_ff) ? s1_level - s1_gray_ff : s1_gray_ff - s1_level;
      s1_is_bg    = (s1_diff <= difference_limit);
      s1_delta    = $signed({1'b0, s1_gray_ff, {FRACTION_BITS{1'b0}}}) - $signed({1'b0, s1_bg});
   end

   assign s2_product = PW'($signed({1'b0, learning_rate})) * PW'(s2_delta_ff);

   always_comb begin
      s3_total = $signed({s3_product_ff[PW-1], s3_product_ff}) + $signed(TW'(ROUND_HALF));
      s3_step  = s3_total[TW-1:LR_SHIFT];
      s3_sum   = $signed({5'b0, s3_bg_ff}) + $signed({s3_step[STW-1], s3_step});
      if (s3_sum[NW-1]) begin
         s3_new_bg = '0;
      end else if (s3_sum > $signed({5'b0, TOP})) begin
         s3_new_bg = TOP;
      end else begin
         s3_new_bg = s3_sum[SW-1:0];
      end
   end

   assign s1_valid_in = issue_valid;
   assign s2_write_in = s1_valid_ff && s1_is_bg;
   assign s3_write_in = s2_write_ff;
   assign wb_valid_in = s3_write_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_write_ff <= 1'b0;
         s3_write_ff <= 1'b0;
         wb_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_write_ff <= s2_write_in;
         s3_write_ff <= s3_write_in;
         wb_valid_ff <= wb_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue_valid) begin
         s1_addr_ff   <= issue_addr;
         s1_gray_ff   <= issue_gray;
         s1_last_ff   <= issue_last;
         s1_primed_ff <= issue_primed;
      end
      s2_addr_ff    <= s1_addr_ff;
      s2_bg_ff      <= s1_bg;
      s2_delta_ff   <= s1_delta;
      s3_addr_ff    <= s2_addr_ff;
      s3_bg_ff      <= s2_bg_ff;
      s3_product_ff <= s2_product;
      wb_addr_ff    <= s3_addr_ff;
      wb_data_ff    <= s3_new_bg;
   end

   assign conflict = (s1_valid_ff && (s1_addr_ff == probe_addr))
                  || (s2_write_ff && (s2_addr_ff == probe_addr));

   assign mem_wr_en   = s3_write_ff;
   assign mem_wr_addr = s3_addr_ff;
   assign mem_wr_data = s3_new_bg;

   assign push_valid = s1_valid_ff;
   always_comb begin
      push_data.is_background    = s1_is_bg;
      push_data.gray_level       = s1_gray_ff;
      push_data.background_level = s1_level;
      push_data.frame_end        = s1_last_ff;
   end

`ifndef ASSERT_OFF
   // A pixel of the first frame always matches, since its own gray level stands in for the background.
   a_unprimed_is_bg: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_primed_ff) |-> s1_is_bg)
      else $error("first-frame pixel classified as foreground");

   // An entry read in s1 must not have an update still pending one stage ahead.
   a_no_stale_read: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s2_write_ff) |-> (s1_addr_ff != s2_addr_ff))
      else $error("read of an entry whose update is still in flight");
`endif

endmodule

### design/rabs_result_fifo.sv
// Small result queue between the update pipeline and the result channel.
module rabs_result_fifo
   import rabs_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push_valid,
   input  result_type                  push_data,
   output logic [FIFO_COUNT_WIDTH-1:0] count,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output result_type                  rsp_data
);

   result_type                  entries_ff [FIFO_DEPTH];
   logic [FIFO_PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_COUNT_WIDTH-1:0] count_ff, count_in;
   logic                        pop;

   assign rsp_valid = (count_ff != '0);
   assign pop       = rsp_valid && !rsp_stall;
   assign rsp_data  = entries_ff[rd_ptr_ff];
   assign count     = count_ff;

   always_comb begin
      wr_ptr_in = push_valid ? wr_ptr_ff + FIFO_PTR_WIDTH'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + FIFO_PTR_WIDTH'(1) : rd_ptr_ff;
      count_in  = count_ff + FIFO_COUNT_WIDTH'(push_valid) - FIFO_COUNT_WIDTH'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> ((count_ff < FIFO_COUNT_WIDTH'(FIFO_DEPTH)) || pop))
      else $error("result beat pushed into a full queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FIFO_COUNT_WIDTH'(FIFO_DEPTH))
      else $error("result queue count beyond its depth");
`endif

endmodule

### design/running_average_background_subtract_unit.sv
// Top level of the running-average background subtraction unit.
//
//   Channel  Direction  Handshake            Beat contents
//   req      in         req_valid/req_stall  req_blue, req_green, req_red
//   rsp      out        rsp_valid/rsp_stall  rsp_is_background, rsp_gray_level,
//                                            rsp_background_level, rsp_frame_end
//   csr      in         csr_write_enable     csr_index, csr_write_data
//
// One pixel beat is accepted per cycle while req_stall is low; its result is registered in s1
// and then in the result queue before it is offered. A pixel whose store entry is still in the first
// two of the three read-modify-write stages waits, which slows frames of one or two pixels.
// Reset clears control state only; the store needs no clearing pass, since first-frame pixels
// ignore the stored value and write every entry of the frame. req_stall also
// rises while the four-entry result queue has no room for the beats already in flight.
module running_average_background_subtract_unit
   import rabs_pkg::*;
#(
   parameter int MAX_PIXELS    = 524288,
   parameter int FRACTION_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [7:0]                req_blue,
   input  logic [7:0]                req_green,
   input  logic [7:0]                req_red,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_is_background,
   output logic [7:0]                rsp_gray_level,
   output logic [7:0]                rsp_background_level,
   output logic                      rsp_frame_end,
   input  logic                      csr_write_enable,
   input  logic [1:0]                csr_index,
   input  logic [CSR_DATA_WIDTH-1:0] csr_write_data
);

   localparam int AW = $clog2(MAX_PIXELS);
   localparam int SW = 8 + FRACTION_BITS;
   localparam int CW = (AW + 1 > PPF_WIDTH) ? AW + 1 : PPF_WIDTH;
   localparam int RESET_FRAME = (PPF_RESET > MAX_PIXELS) ? MAX_PIXELS : PPF_RESET;
   localparam logic [AW-1:0] RESET_LAST = AW'(RESET_FRAME - 1);
   localparam logic [AW-1:0] MAX_LAST   = AW'(MAX_PIXELS - 1);

   logic [LR_WIDTH-1:0]    learning_rate_ff, learning_rate_in;
   logic [LIMIT_WIDTH-1:0] difference_limit_ff, difference_limit_in;
   logic [AW-1:0]          frame_last_ff, frame_last_in;
   logic [AW-1:0]          pos_ff, pos_in;
   logic                   primed_ff, primed_in;

   logic [LR_WIDTH-1:0]    lr_data;
   logic [CW-1:0]          ppf_data;
   logic [AW-1:0]          last_data;

   logic                   accept;
   logic                   at_last;
   logic [7:0]             gray;
   logic                   conflict;

   logic                   mem_wr_en;
   logic [AW-1:0]          mem_wr_addr;
   logic [SW-1:0]          mem_wr_data;
   logic [SW-1:0]          mem_rd_data;

   logic                        push_valid;
   result_type                  push_data;
   result_type                  head;
   logic [FIFO_COUNT_WIDTH-1:0] fifo_count;
   logic [FIFO_COUNT_WIDTH-1:0] occupancy;

   always_comb begin
      lr_data  = csr_write_data[LR_WIDTH-1:0];
      ppf_data = CW'(csr_write_data[PPF_WIDTH-1:0]);
      if (ppf_data == '0) begin
         last_data = '0;
      end else if (ppf_data > CW'(MAX_PIXELS)) begin
         last_data = MAX_LAST;
      end else begin
         last_data = AW'(ppf_data - CW'(1));
      end

      learning_rate_in    = learning_rate_ff;
      difference_limit_in = difference_limit_ff;
      frame_last_in       = frame_last_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_LEARNING_RATE: begin
               learning_rate_in = (lr_data > LR_ONE) ? LR_ONE : lr_data;
            end
            CSR_DIFFERENCE_LIMIT: begin
               difference_limit_in = csr_write_data[LIMIT_WIDTH-1:0];
            end
            CSR_PIXELS_PER_FRAME: begin
               frame_last_in = last_data;
            end
            default: begin
            end
         endcase
      end
   end

   assign occupancy = fifo_count + FIFO_COUNT_WIDTH'(push_valid);
   assign req_stall = conflict || (occupancy >= FIFO_COUNT_WIDTH'(FIFO_DEPTH));
   assign accept    = req_valid && !req_stall;
   assign at_last   = (pos_ff >= frame_last_ff);
   assign gray      = to_gray(req_red, req_green, req_blue);

   always_comb begin
      pos_in    = pos_ff;
      primed_in = primed_ff;
      if (accept) begin
         pos_in    = at_last ? '0 : pos_ff + AW'(1);
         primed_in = primed_ff || at_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         learning_rate_ff    <= LR_RESET;
         difference_limit_ff <= LIMIT_RESET;
         frame_last_ff       <= RESET_LAST;
         pos_ff              <= '0;
         primed_ff           <= 1'b0;
      end else begin
         learning_rate_ff    <= learning_rate_in;
         difference_limit_ff <= difference_limit_in;
         frame_last_ff       <= frame_last_in;
         pos_ff              <= pos_in;
         primed_ff           <= primed_in;
      end
   end

   rabs_store_mem #(
      .DEPTH      (MAX_PIXELS),
      .WIDTH      (SW),
      .ADDR_WIDTH (AW)
   ) u_store (
      .clock      (clock),
      .wr_en      (mem_wr_en),
      .wr_addr    (mem_wr_addr),
      .wr_data    (mem_wr_data),
      .rd_en      (accept),
      .rd_addr    (pos_ff),
      .rd_data_ff (mem_rd_data)
   );

   rabs_update_pipe #(
      .ADDR_WIDTH    (AW),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_pipe (
      .clock            (clock),
      .reset            (reset),
      .learning_rate    (learning_rate_ff),
      .difference_limit (difference_limit_ff),
      .issue_valid      (accept),
      .issue_addr       (pos_ff),
      .issue_gray       (gray),
      .issue_last       (at_last),
      .issue_primed     (primed_ff),
      .probe_addr       (pos_ff),
      .conflict         (conflict),
      .mem_rd_data      (mem_rd_data),
      .mem_wr_en        (mem_wr_en),
      .mem_wr_addr      (mem_wr_addr),
      .mem_wr_data      (mem_wr_data),
      .push_valid       (push_valid),
      .push_data        (push_data)
   );

   rabs_result_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .count      (fifo_count),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (head)
   );

   assign rsp_is_background    = head.is_background;
   assign rsp_gray_level       = head.gray_level;
   assign rsp_background_level = head.background_level;
   assign rsp_frame_end        = head.frame_end;

`ifndef ASSERT_OFF
   a_wrap_after_last: assert property (@(posedge clock) disable iff (reset)
      (accept && at_last) |=> (pos_ff == '0))
      else $error("pixel position did not wrap after the last pixel of a frame");

   a_advance_by_one: assert property (@(posedge clock) disable iff (reset)
      (accept && !at_last) |=> (pos_ff == $past(pos_ff) + AW'(1)))
      else $error("pixel position did not advance by one");
`endif

endmodule
